FILE: rtl/lvps_pkg.sv
package lvps_pkg;

	// Stack geometry and string limit.
	localparam int STACK_DEPTH = 1024;
	localparam int MAX_CHARS   = 65536;

	localparam int POS_W   = 16;                        // stored position of an open
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);   // stack fill, 0 to STACK_DEPTH
	localparam int CHPOS_W = 17;                        // character position, 0 to MAX_CHARS
	localparam int LEN_W   = 17;
	localparam int ERR_W   = 2;
	localparam int CHAR_W  = 8;

	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [ERR_W-1:0]   err_t;

	// Movement of the whole cell row.
	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP
	} stk_op_t;

endpackage

FILE: rtl/lvps_chars_if.sv
interface lvps_chars_if;
	logic           valid;
	logic           ready;
	lvps_pkg::char_t char_code;
	logic           is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

FILE: rtl/lvps_result_if.sv
interface lvps_result_if;
	logic           valid;
	logic           ready;
	lvps_pkg::len_t best_length;
	lvps_pkg::pos_t best_start;
	lvps_pkg::err_t error_code;

	modport source (output valid, output best_length, output best_start, output error_code,
		input ready);
	modport sink   (input valid, input best_length, input best_start, input error_code,
		output ready);
endinterface

FILE: rtl/lvps_cell.sv
module lvps_cell (
	input  logic              clk,
	input  lvps_pkg::stk_op_t op,
	input  lvps_pkg::pos_t    from_above,
	input  lvps_pkg::pos_t    from_below,
	output lvps_pkg::pos_t    value
);
	import lvps_pkg::*;

	pos_t value_q;

	// A push moves every entry one cell deeper, a pop one cell toward the top.
	always_ff @(posedge clk) begin
		case (op)
			STK_PUSH: value_q <= from_above;
			STK_POP:  value_q <= from_below;
			default:  value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

FILE: rtl/lvps_stack.sv
module lvps_stack (
	input  logic              clk,
	input  lvps_pkg::stk_op_t op,
	input  lvps_pkg::pos_t    push_pos,
	output lvps_pkg::pos_t    second
);
	import lvps_pkg::*;

	pos_t cell_val [STACK_DEPTH];

	// Cell 0 is the top of the stack; the deepest cell refills from itself on a pop.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		pos_t above;
		pos_t below;

		if (i == 0) begin : g_top
			assign above = push_pos;
		end else begin : g_mid
			assign above = cell_val[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign below = cell_val[i];
		end else begin : g_inner
			assign below = cell_val[i+1];
		end

		lvps_cell u_cell (
			.clk        (clk),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.value      (cell_val[i])
		);
	end

	// After a pop the new top is what sits in cell 1 now.
	assign second = cell_val[1];

endmodule

FILE: rtl/longest_valid_paren_span_unit.sv
// Channel   Direction  Beat contents                          Accepted when
// chars     in         char_code, is_last                     valid && ready
// result    out        best_length, best_start, error_code    valid && ready
//
// Every character beat is handled in the cycle it is accepted, so the unit takes one
// beat per clock while chars.ready is high; the cell row and the span compare update together.
// A result is presented in the cycle after the last character of a string is accepted.
// The result sits in an output register; chars.ready drops only while that register is
// full and result.ready is low, so no new character is accepted while a result waits.
// arst_n clears the control state at once; the cell row needs no clearing pass.
module longest_valid_paren_span_unit (
	input  logic                clk,
	input  logic                arst_n,
	lvps_chars_if.sink          chars,
	lvps_result_if.source       result
);
	import lvps_pkg::*;

	// Per-string state.
	logic [CNT_W-1:0]   count_q;
	logic [CHPOS_W-1:0] char_pos_q;
	logic [CHPOS_W-1:0] left_q;      // all ones stands for "before the string"
	len_t               best_len_q;
	pos_t               best_start_q;
	err_t               error_q;

	// Output register.
	logic res_valid_q;
	len_t res_len_q;
	pos_t res_start_q;
	err_t res_err_q;

	logic accept;
	stk_op_t stk_op;
	pos_t second;

	logic [CNT_W-1:0]   count_d;
	logic [CHPOS_W-1:0] char_pos_d;
	logic [CHPOS_W-1:0] left_d;
	len_t               best_len_d;
	pos_t               best_start_d;
	err_t               error_d;

	assign chars.ready = !res_valid_q || result.ready;
	assign accept      = chars.valid && chars.ready;

	lvps_stack u_stack (
		.clk      (clk),
		.op       (stk_op),
		.push_pos (char_pos_q[POS_W-1:0]),
		.second   (second)
	);

	// Next state for one character. A close that empties the stack measures from the left
	// boundary; otherwise it measures from the open now on top, which is cell 1 before the pop.
	always_comb begin
		logic               too_long;
		logic [CHPOS_W-1:0] anchor;
		logic [CHPOS_W-1:0] span;

		count_d      = count_q;
		char_pos_d   = char_pos_q;
		left_d       = left_q;
		best_len_d   = best_len_q;
		best_start_d = best_start_q;
		error_d      = error_q;
		stk_op       = STK_HOLD;

		too_long = (char_pos_q >= CHPOS_W'(MAX_CHARS));
		anchor   = (count_q == CNT_W'(1)) ? left_q : {1'b0, second};
		span     = char_pos_q - anchor;

		if (accept) begin
			if (too_long) begin
				// Over-length characters are dropped without advancing the position.
				if (error_q == ERR_NONE) begin
					error_d = ERR_TOO_LONG;
				end
			end else begin
				char_pos_d = char_pos_q + CHPOS_W'(1);
				if (chars.char_code == CH_OPEN) begin
					if (count_q == CNT_W'(STACK_DEPTH)) begin
						if (error_q == ERR_NONE) begin
							error_d = ERR_OVERFLOW;
						end
					end else begin
						stk_op  = STK_PUSH;
						count_d = count_q + CNT_W'(1);
					end
				end else if (chars.char_code == CH_CLOSE) begin
					if (count_q == '0) begin
						left_d = char_pos_q;
					end else begin
						stk_op  = STK_POP;
						count_d = count_q - CNT_W'(1);
						if (span > best_len_q) begin
							best_len_d   = span;
							best_start_d = POS_W'(anchor + CHPOS_W'(1));
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			char_pos_q   <= '0;
			left_q       <= '1;
			best_len_q   <= '0;
			best_start_q <= '0;
			error_q      <= ERR_NONE;
		end else if (accept && chars.is_last) begin
			// The string ends here: start the next one from a clean slate.
			count_q      <= '0;
			char_pos_q   <= '0;
			left_q       <= '1;
			best_len_q   <= '0;
			best_start_q <= '0;
			error_q      <= ERR_NONE;
		end else begin
			count_q      <= count_d;
			char_pos_q   <= char_pos_d;
			left_q       <= left_d;
			best_len_q   <= best_len_d;
			best_start_q <= best_start_d;
			error_q      <= error_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && chars.is_last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// The last character's own effect is part of the result.
	always_ff @(posedge clk) begin
		if (accept && chars.is_last) begin
			res_len_q   <= best_len_d;
			res_start_q <= best_start_d;
			res_err_q   <= error_d;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.best_length = res_len_q;
	assign result.best_start  = res_start_q;
	assign result.error_code  = res_err_q;

endmodule
